[hdl/swep_pkg.sv]
`timescale 1ns / 1ps

package swep_pkg;

  localparam int unsigned NODE_W   = 10;
  localparam int unsigned DEG_IN_W = 16;
  localparam int unsigned DRAW_W   = 26;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CFG_RESET = 1024;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONNECT = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SELF_LOOP = 2'd1;
  localparam logic [1:0] STATUS_BAD_DRAW  = 2'd2;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_LOAD_WR,
    S_SCAN,
    S_UPD_A,
    S_UPD_B,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                operation;
    logic [NODE_W-1:0]   node_index;
    logic [DEG_IN_W-1:0] degree_value;
    logic [DRAW_W-1:0]   first_draw;
    logic [DRAW_W-1:0]   second_draw;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic              edge_made;
    logic [1:0]        status;
    logic [DRAW_W-1:0] free_total;
    logic              can_connect;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic load_rd;
    logic load_wr;
    logic scan_start;
    logic scan_step;
    logic upd_a;
    logic upd_b;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic bad;
    logic clr_last;
    logic scan_done;
    logic self_loop;
  } sts_t;

endpackage

[hdl/swep_stream_if.sv]
`timescale 1ns / 1ps

interface swep_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/swep_ctrl.sv]
`timescale 1ns / 1ps

module swep_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic             cfg_we_i,
  input  swep_pkg::sts_t   sts_i,
  output swep_pkg::cmd_t   cmd_o
);

  swep_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      swep_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = swep_pkg::S_IDLE;
      end
      swep_pkg::S_IDLE: begin
        if (in_valid_i) state_d = swep_pkg::S_DISPATCH;
      end
      swep_pkg::S_DISPATCH: begin
        if (sts_i.bad) begin
          state_d = swep_pkg::S_DONE;
        end else if (sts_i.is_load) begin
          state_d = swep_pkg::S_LOAD_WR;
        end else begin
          state_d = swep_pkg::S_SCAN;
        end
      end
      swep_pkg::S_LOAD_WR: state_d = swep_pkg::S_DONE;
      swep_pkg::S_SCAN: begin
        if (sts_i.scan_done) state_d = swep_pkg::S_UPD_A;
      end
      swep_pkg::S_UPD_A: begin
        state_d = sts_i.self_loop ? swep_pkg::S_DONE : swep_pkg::S_UPD_B;
      end
      swep_pkg::S_UPD_B: state_d = swep_pkg::S_DONE;
      swep_pkg::S_DONE: begin
        if (out_free) state_d = swep_pkg::S_IDLE;
      end
      default: state_d = swep_pkg::S_CLEAR;
    endcase
    if (cfg_we_i) state_d = swep_pkg::S_CLEAR;
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      swep_pkg::S_CLEAR: cmd_o.clr_step = 1'b1;
      swep_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      swep_pkg::S_DISPATCH: begin
        cmd_o.load_rd = !sts_i.bad && sts_i.is_load;
        cmd_o.scan_start = !sts_i.bad && !sts_i.is_load;
      end
      swep_pkg::S_LOAD_WR: cmd_o.load_wr = 1'b1;
      swep_pkg::S_SCAN: cmd_o.scan_step = 1'b1;
      swep_pkg::S_UPD_A: cmd_o.upd_a = !sts_i.self_loop;
      swep_pkg::S_UPD_B: cmd_o.upd_b = 1'b1;
      swep_pkg::S_DONE: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swep_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/swep_dp.sv]
`timescale 1ns / 1ps

module swep_dp #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned DEGREE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swep_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  swep_pkg::in_word_t             in_data_i,
  input  swep_pkg::cmd_t                 cmd_i,
  output swep_pkg::sts_t                 sts_o,
  output swep_pkg::out_word_t            out_data_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned CW = NW + 1;
  localparam int unsigned TW = DEGREE_BITS + NW;
  localparam int unsigned ACT_RESET =
    (swep_pkg::CFG_RESET > MAX_NODES) ? MAX_NODES : swep_pkg::CFG_RESET;

  logic [DEGREE_BITS-1:0] mem_q [MAX_NODES];

  logic                             op_q;
  logic [swep_pkg::NODE_W-1:0]      node_q;
  logic [DEGREE_BITS-1:0]           deg_q;
  logic [swep_pkg::DRAW_W-1:0]      d1_q, d2_q;
  logic                             bad_q, bad_d;
  logic [CW-1:0]                    act_q, act_d;
  logic [TW-1:0]                    total_q, total_d;
  logic [CW-1:0]                    nz_q, nz_d;
  logic [NW-1:0]                    clr_cnt_q;
  logic [CW-1:0]                    cnt_q;
  logic                             vld_q;
  logic [NW-1:0]                    sidx_q;
  logic [TW-1:0]                    cum_q, cum_d;
  logic                             fa_q, fb_q;
  logic [NW-1:0]                    a_q, b_q;
  logic [DEGREE_BITS-1:0]           va_q, vb_q;
  logic [DEGREE_BITS-1:0]           rd_q;
  swep_pkg::out_word_t              out_q, out_d;

  logic                   issue, rd_en, we, last, hit1, hit2, clr_last;
  logic [NW-1:0]          rd_addr, wr_addr, node_addr;
  logic [DEGREE_BITS-1:0] wr_data;
  logic [31:0]            cfg_wide;

  assign node_addr = NW'(node_q);
  assign issue     = cmd_i.scan_step && (cnt_q < act_q);
  assign rd_en     = cmd_i.load_rd || issue;
  assign rd_addr   = cmd_i.load_rd ? node_addr : cnt_q[NW-1:0];
  assign clr_last  = cmd_i.clr_step && (clr_cnt_q == NW'(MAX_NODES - 1));

  always_comb begin
    we      = 1'b0;
    wr_addr = clr_cnt_q;
    wr_data = '0;
    if (cmd_i.clr_step) begin
      we = 1'b1;
    end else if (cmd_i.load_wr) begin
      we      = 1'b1;
      wr_addr = node_addr;
      wr_data = deg_q;
    end else if (cmd_i.upd_a) begin
      we      = 1'b1;
      wr_addr = a_q;
      wr_data = va_q - DEGREE_BITS'(1);
    end else if (cmd_i.upd_b) begin
      we      = 1'b1;
      wr_addr = b_q;
      wr_data = vb_q - DEGREE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    cfg_wide = 32'(cfg_wdata_i);
    if (cfg_wide == 32'd0) begin
      act_d = CW'(1);
    end else if (cfg_wide > MAX_NODES) begin
      act_d = CW'(MAX_NODES);
    end else begin
      act_d = CW'(cfg_wide);
    end
  end

  always_comb begin
    if (in_data_i.operation == swep_pkg::OP_LOAD) begin
      bad_d = 32'(in_data_i.node_index) >= 32'(act_q);
    end else begin
      bad_d = (in_data_i.first_draw == '0) || (in_data_i.second_draw == '0) ||
              (64'(in_data_i.first_draw) > 64'(total_q)) ||
              (64'(in_data_i.second_draw) > 64'(total_q));
    end
  end

  assign cum_d = cum_q + TW'(rd_q);
  assign last  = CW'(sidx_q) == (act_q - CW'(1));
  assign hit1  = (64'(cum_d) >= 64'(d1_q)) || last;
  assign hit2  = (64'(cum_d) >= 64'(d2_q)) || last;

  always_comb begin
    total_d = total_q;
    nz_d    = nz_q;
    if (cmd_i.load_wr) begin
      total_d = total_q - TW'(rd_q) + TW'(deg_q);
      nz_d    = nz_q - CW'(rd_q != '0) + CW'(deg_q != '0);
    end else if (cmd_i.upd_b) begin
      total_d = total_q - TW'(2);
      nz_d    = nz_q - CW'(va_q == DEGREE_BITS'(1)) - CW'(vb_q == DEGREE_BITS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= CW'(ACT_RESET);
      total_q   <= '0;
      nz_q      <= '0;
      clr_cnt_q <= '0;
      cnt_q     <= '0;
      vld_q     <= 1'b0;
      fa_q      <= 1'b0;
      fb_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        act_q     <= act_d;
        total_q   <= '0;
        nz_q      <= '0;
        clr_cnt_q <= '0;
      end else begin
        total_q <= total_d;
        nz_q    <= nz_d;
        if (cmd_i.clr_step) clr_cnt_q <= clr_last ? '0 : clr_cnt_q + NW'(1);
      end
      if (cmd_i.scan_start) begin
        cnt_q <= '0;
        vld_q <= 1'b0;
        fa_q  <= 1'b0;
        fb_q  <= 1'b0;
      end else begin
        vld_q <= issue;
        if (issue) cnt_q <= cnt_q + CW'(1);
        if (vld_q) begin
          if (!fa_q && hit1) fa_q <= 1'b1;
          if (!fb_q && hit2) fb_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_data_i.operation;
      node_q <= in_data_i.node_index;
      deg_q  <= DEGREE_BITS'(in_data_i.degree_value);
      d1_q   <= in_data_i.first_draw;
      d2_q   <= in_data_i.second_draw;
      bad_q  <= bad_d;
    end
    if (cmd_i.scan_start) cum_q <= '0;
    else if (vld_q) cum_q <= cum_d;
    if (issue) sidx_q <= cnt_q[NW-1:0];
    if (vld_q && !cmd_i.scan_start) begin
      if (!fa_q && hit1) begin
        a_q  <= sidx_q;
        va_q <= rd_q;
      end
      if (!fb_q && hit2) begin
        b_q  <= sidx_q;
        vb_q <= rd_q;
      end
    end
    if (cmd_i.out_load) out_q <= out_d;
  end

  always_comb begin
    out_d             = '0;
    out_d.free_total  = swep_pkg::DRAW_W'(total_q);
    out_d.can_connect = nz_q >= CW'(2);
    if (op_q == swep_pkg::OP_LOAD) begin
      out_d.first_node = node_q;
      out_d.status     = bad_q ? swep_pkg::STATUS_BAD_INDEX : swep_pkg::STATUS_OK;
    end else if (bad_q) begin
      out_d.status = swep_pkg::STATUS_BAD_DRAW;
    end else begin
      out_d.first_node  = swep_pkg::NODE_W'(a_q);
      out_d.second_node = swep_pkg::NODE_W'(b_q);
      out_d.edge_made   = a_q != b_q;
      out_d.status      = (a_q == b_q) ? swep_pkg::STATUS_SELF_LOOP : swep_pkg::STATUS_OK;
    end
  end

  assign sts_o.is_load   = op_q == swep_pkg::OP_LOAD;
  assign sts_o.bad       = bad_q;
  assign sts_o.clr_last  = clr_last;
  assign sts_o.scan_done = vld_q && (fa_q || hit1) && (fb_q || hit2);
  assign sts_o.self_loop = a_q == b_q;
  assign out_data_o      = out_q;

endmodule

[hdl/stub_weighted_edge_pairing.sv]
`timescale 1ns / 1ps
// Accepted words are handled one at a time: a load reads the old table entry and then
// writes the new degree; a rejected index or draw goes straight to the result; a connect
// sums the table from entry 0, one entry per cycle up to node_count entries, until both
// draws are covered, then decrements both endpoints (a self loop writes nothing).
// Reset, and every node_count write, clears all MAX_NODES table entries in a pass
// during which no input word is accepted.

module stub_weighted_edge_pairing #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned DEGREE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  swep_stream_if.sink                in_i,
  swep_stream_if.source              out_o,
  input  logic                       cfg_we_i,
  input  logic [swep_pkg::CFG_W-1:0] cfg_wdata_i
);

  swep_pkg::cmd_t cmd;
  swep_pkg::sts_t sts;

  swep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cfg_we_i    (cfg_we_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swep_dp #(
    .MAX_NODES   (MAX_NODES),
    .DEGREE_BITS (DEGREE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_o.data)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !in_i.ready)
    else $error("input accepted while a word is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.out_load))
    else $error("result raised without a load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_step, cmd.load_wr, cmd.upd_a, cmd.upd_b}))
    else $error("two writes to the stub table at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.upd_a && !cfg_we_i) |=> cmd.upd_b)
    else $error("second endpoint update missed");

endmodule
